// ===== src/button_multi_click_detector_assert.svh =====
// Assertion helpers shared by the detector's RTL files.
`ifndef BUTTON_MULTI_CLICK_DETECTOR_ASSERT_SVH
`define BUTTON_MULTI_CLICK_DETECTOR_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define BMC_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BMC_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define BMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/bmc_pkg.sv =====
`timescale 1ns / 1ps

package bmc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int THRESH_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_REPEAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd4;

  localparam logic [THRESH_W-1:0] LONG_PRESS_RST  = 16'd100;
  localparam logic [THRESH_W-1:0] LONG_REPEAT_RST = 16'd100;
  localparam logic [THRESH_W-1:0] GAP_RST         = 16'd50;

  typedef enum logic [3:0] {
    EV_NONE          = 4'd0,
    EV_FIRST_PUSH    = 4'd1,
    EV_FIRST_LONG    = 4'd2,
    EV_FIRST_REPEAT  = 4'd3,
    EV_FIRST_RELEASE = 4'd4,
    EV_SINGLE_DONE   = 4'd5,
    EV_SECOND_PUSH   = 4'd6,
    EV_SECOND_LONG   = 4'd7,
    EV_SECOND_REPEAT = 4'd8,
    EV_SECOND_RELEASE = 4'd9,
    EV_DOUBLE_DONE   = 4'd10,
    EV_THIRD_PUSH    = 4'd11,
    EV_TRIPLE_DONE   = 4'd12,
    EV_RESET         = 4'd13
  } event_e;

  typedef struct packed {
    logic                enable;
    logic                active_level;
    logic [THRESH_W-1:0] long_press;
    logic [THRESH_W-1:0] long_repeat;
    logic [THRESH_W-1:0] gap;
  } cfg_t;

  // Debounced level handed to the click machine for one beat.
  typedef struct packed {
    logic step;
    logic push;
  } click_in_t;

endpackage

// ===== src/button_multi_click_detector.sv =====
// A pin beat accepted into the input register reaches the result register when the output advances.
// Throughput: one beat per cycle unless output stalls; click machine updates per beat, debouncer per enabled beat.
// Input register and result register let a new beat in while a result waits.
// Reset: asynchronous, active low; clears pipeline valids, debouncer and click
// state, and loads the registers with enable 1, active level 0, 100/100/50 ticks.
`timescale 1ns / 1ps

`include "button_multi_click_detector_assert.svh"

module button_multi_click_detector #(
  parameter int DEBOUNCE_SAMPLES = 3,
  parameter int COUNT_WIDTH      = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           pin_level_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [3:0]                     event_res_o,
  output logic                           pressed_o
);

  bmc_pkg::cfg_t      cfg;
  bmc_pkg::click_in_t click;
  bmc_pkg::event_e    event_d;

  logic s1_valid_q, s1_valid_d;
  logic s1_pin_q;
  logic out_valid_q;
  logic [3:0] event_q;
  logic pressed_q, pressed_d;
  logic advance, beat, in_acc;

  assign advance    = !out_valid_q || !out_stall_i;
  assign beat       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !advance);

  bmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bmc_debounce #(
    .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES)
  ) u_debounce (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (beat && cfg.enable),
    .pin_i          (s1_pin_q),
    .active_level_i (cfg.active_level),
    .click_o        (click),
    .level_o        (pressed_d)
  );

  bmc_click_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .cfg_i   (cfg),
    .click_i (click),
    .event_o (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers: input on accept, result on each beat; drop nothing while stalled
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pin_q <= pin_level_i;
    end
    if (beat) begin
      event_q   <= event_d;
      pressed_q <= pressed_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;
  assign pressed_o   = pressed_q;

  `BMC_ASSERT_NEXT(a_hold_stage, clk_i, rst_ni, s1_valid_q && !advance, s1_valid_q, "stalled input beat lost")
  `BMC_ASSERT_NEXT(a_accept_loads, clk_i, rst_ni, in_acc, s1_valid_q, "accepted beat not captured")
  `BMC_ASSERT_NEXT(a_disabled_none, clk_i, rst_ni, beat && !cfg.enable, out_valid_q && event_q == bmc_pkg::EV_NONE, "disabled beat must report no event")
  `BMC_ASSERT(a_stall_only_full, clk_i, rst_ni, in_stall_o, out_valid_q && s1_valid_q, "input stalled with room in the pipeline")

endmodule

// ===== src/bmc_cfg_regs.sv =====
`timescale 1ns / 1ps

module bmc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bmc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output bmc_pkg::cfg_t                    cfg_o
);

  bmc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b1;
      cfg_q.active_level <= 1'b0;
      cfg_q.long_press   <= bmc_pkg::LONG_PRESS_RST;
      cfg_q.long_repeat  <= bmc_pkg::LONG_REPEAT_RST;
      cfg_q.gap          <= bmc_pkg::GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmc_pkg::CFG_ENABLE:       cfg_q.enable       <= cfg_wdata_i[0];
        bmc_pkg::CFG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_wdata_i[0];
        bmc_pkg::CFG_LONG_PRESS:   cfg_q.long_press   <= cfg_wdata_i;
        bmc_pkg::CFG_LONG_REPEAT:  cfg_q.long_repeat  <= cfg_wdata_i;
        bmc_pkg::CFG_GAP:          cfg_q.gap          <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/bmc_debounce.sv =====
`timescale 1ns / 1ps

module bmc_debounce #(
  parameter int DEBOUNCE_SAMPLES = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               pin_i,
  input  logic               active_level_i,
  output bmc_pkg::click_in_t click_o,
  output logic               level_o
);

  localparam logic [1:0] RUN_LIMIT = 2'(DEBOUNCE_SAMPLES);

  logic       now_q, now_d;
  logic       prev_q, prev_d;
  logic       level_q, level_d;
  logic [1:0] run_q, run_d;

  always_comb begin
    prev_d  = now_q;
    now_d   = pin_i;
    level_d = level_q;
    run_d   = (now_d == prev_d) ? run_q + 2'd1 : 2'd0;
    if (run_d >= RUN_LIMIT) begin
      run_d   = 2'd0;
      level_d = (now_d == active_level_i);
    end
    // hold everything while not clocked
    if (!step_i) begin
      prev_d  = prev_q;
      now_d   = now_q;
      level_d = level_q;
      run_d   = run_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= 1'b0;
      prev_q  <= 1'b0;
      level_q <= 1'b0;
      run_q   <= 2'd0;
    end else begin
      now_q   <= now_d;
      prev_q  <= prev_d;
      level_q <= level_d;
      run_q   <= run_d;
    end
  end

  assign click_o.step = step_i;
  assign click_o.push = level_d;
  assign level_o      = level_d;

endmodule

// ===== src/bmc_click_fsm.sv =====
`timescale 1ns / 1ps

`include "button_multi_click_detector_assert.svh"

module bmc_click_fsm #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  bmc_pkg::cfg_t      cfg_i,
  input  bmc_pkg::click_in_t click_i,
  output bmc_pkg::event_e    event_o
);

  localparam int CMP_W = (COUNT_WIDTH > bmc_pkg::THRESH_W) ? COUNT_WIDTH : bmc_pkg::THRESH_W;

  typedef enum logic [3:0] {
    S_INIT        = 4'd0,
    S_WAIT        = 4'd1,
    S_FIRST_DOWN  = 4'd2,
    S_FIRST_LONG  = 4'd3,
    S_FIRST_UP    = 4'd4,
    S_SECOND_DOWN = 4'd5,
    S_SECOND_LONG = 4'd6,
    S_SECOND_UP   = 4'd7,
    S_THIRD_DOWN  = 4'd8
  } state_e;

  state_e                 state_q, state_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [CMP_W-1:0]       inc_x;
  logic                   hit_press, hit_repeat, hit_gap;
  logic                   push;

  assign push       = click_i.push;
  assign tick_inc   = tick_q + 1'b1;
  assign inc_x      = CMP_W'(tick_inc);
  assign hit_press  = inc_x >= CMP_W'(cfg_i.long_press);
  assign hit_repeat = inc_x >= CMP_W'(cfg_i.long_repeat);
  assign hit_gap    = inc_x >= CMP_W'(cfg_i.gap);

  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    event_o = bmc_pkg::EV_NONE;
    if (!cfg_i.enable) begin
      state_d = S_INIT;
      tick_d  = '0;
    end else begin
      unique case (state_q)
        S_INIT: begin
          tick_d  = '0;
          state_d = S_WAIT;
        end
        S_WAIT: begin
          if (push) begin
            state_d = S_FIRST_DOWN;
            event_o = bmc_pkg::EV_FIRST_PUSH;
          end
        end
        S_FIRST_DOWN: begin
          if (push) begin
            tick_d = tick_inc;
            if (hit_press) begin
              tick_d  = '0;
              state_d = S_FIRST_LONG;
              event_o = bmc_pkg::EV_FIRST_LONG;
            end
          end else begin
            // count carries over into the gap timing
            state_d = S_FIRST_UP;
            event_o = bmc_pkg::EV_FIRST_RELEASE;
          end
        end
        S_FIRST_LONG: begin
          if (push) begin
            tick_d = tick_inc;
            if (hit_repeat) begin
              tick_d  = '0;
              event_o = bmc_pkg::EV_FIRST_REPEAT;
            end
          end else begin
            tick_d  = '0;
            state_d = S_WAIT;
            event_o = bmc_pkg::EV_RESET;
          end
        end
        S_FIRST_UP: begin
          if (push) begin
            tick_d  = '0;
            state_d = S_SECOND_DOWN;
            event_o = bmc_pkg::EV_SECOND_PUSH;
          end else begin
            tick_d = tick_inc;
            if (hit_gap) begin
              tick_d  = '0;
              state_d = S_WAIT;
              event_o = bmc_pkg::EV_SINGLE_DONE;
            end
          end
        end
        S_SECOND_DOWN: begin
          if (push) begin
            tick_d = tick_inc;
            if (hit_press) begin
              tick_d  = '0;
              state_d = S_SECOND_LONG;
              event_o = bmc_pkg::EV_SECOND_LONG;
            end
          end else begin
            tick_d  = '0;
            state_d = S_SECOND_UP;
            event_o = bmc_pkg::EV_SECOND_RELEASE;
          end
        end
        S_SECOND_LONG: begin
          if (push) begin
            tick_d = tick_inc;
            if (hit_repeat) begin
              tick_d  = '0;
              event_o = bmc_pkg::EV_SECOND_REPEAT;
            end
          end else begin
            tick_d  = '0;
            state_d = S_INIT;
            event_o = bmc_pkg::EV_RESET;
          end
        end
        S_SECOND_UP: begin
          if (push) begin
            tick_d  = '0;
            state_d = S_THIRD_DOWN;
            event_o = bmc_pkg::EV_THIRD_PUSH;
          end else begin
            tick_d = tick_inc;
            if (hit_gap) begin
              tick_d  = '0;
              state_d = S_WAIT;
              event_o = bmc_pkg::EV_DOUBLE_DONE;
            end
          end
        end
        S_THIRD_DOWN: begin
          if (!push) begin
            tick_d  = '0;
            state_d = S_WAIT;
            event_o = bmc_pkg::EV_TRIPLE_DONE;
          end
        end
        default: ;  // hold on codes outside the machine
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      tick_q  <= '0;
    end else if (beat_i) begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  `BMC_ASSERT_NEXT(a_init_to_wait, clk_i, rst_ni, beat_i && cfg_i.enable && state_q == S_INIT, state_q == S_WAIT, "first enabled beat must leave the initial state")
  `BMC_ASSERT_NEXT(a_disable_clears, clk_i, rst_ni, beat_i && !cfg_i.enable, state_q == S_INIT && tick_q == '0, "disabled beat must clear the click machine")
  `BMC_ASSERT(a_step_matches, clk_i, rst_ni, beat_i && cfg_i.enable, click_i.step, "debouncer must be clocked on every enabled beat")

endmodule

// ===== tb/button_multi_click_detector_test.sv =====
`timescale 1ns / 1ps

module button_multi_click_detector_test;

  localparam int DEBOUNCE    = 3;
  localparam int COUNT_W     = 16;
  localparam int STALL_LIMIT = 500;
  localparam int ITEM_TARGET = 1350;
  localparam int PHASE_ITEMS = 110;

  typedef logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [bmc_pkg::CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t STRAY_IDX_LO = bmc_pkg::CFG_GAP + 1'b1;
  localparam cfg_idx_t STRAY_IDX_HI = '1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_WAIT,
    ST_PUSH1,
    ST_LONG1,
    ST_GAP1,
    ST_PUSH2,
    ST_LONG2,
    ST_GAP2,
    ST_PUSH3
  } click_state_e;

  typedef struct packed {
    bmc_pkg::event_e ev;
    logic            pressed;
  } click_result_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  cfg_idx_t  cfg_idx_i   = bmc_pkg::CFG_ENABLE;
  cfg_data_t cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  logic      pin_level_i = 1'b0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  logic [3:0] event_res_o;
  logic      pressed_o;

  // Mirror of the detector: setup registers, debouncer and click machine.
  bmc_pkg::cfg_t      det_cfg;
  click_state_e       click_st;
  logic [COUNT_W-1:0] tick_cnt;
  logic               smp_now;
  logic               smp_prev;
  logic               stable_lvl;
  logic [1:0]         stable_cnt;

  logic          pin_backlog[$];
  click_result_t pending_events[$];
  int            mismatches   = 0;
  int            items_queued = 0;
  int            idle_cycles  = 0;
  int            pin_gap      = 0;
  int            res_wait     = 0;
  bit            steady       = 1'b0;

  button_multi_click_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pin_level_i (pin_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .pressed_o   (pressed_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_pause();
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic int clamp_ticks(int want, int cap);
    return (want > cap) ? cap : want;
  endfunction

  function automatic logic count_up_reaches(logic [COUNT_W-1:0] limit);
    tick_cnt = tick_cnt + 1'b1;
    return tick_cnt >= limit;
  endfunction

  // Advance the mirror by one pin sample and return the event it gives.
  function automatic click_result_t predict_tick(logic pin);
    bmc_pkg::event_e ev;
    logic            push;
    click_result_t   res;
    ev = bmc_pkg::EV_NONE;
    if (!det_cfg.enable) begin
      tick_cnt = '0;
      click_st = ST_INIT;
    end else begin
      smp_prev = smp_now;
      smp_now  = pin;
      if (smp_now == smp_prev) stable_cnt = stable_cnt + 2'd1;
      else stable_cnt = '0;
      if (stable_cnt >= DEBOUNCE) begin
        stable_cnt = '0;
        stable_lvl = (smp_now == det_cfg.active_level);
      end
      push = stable_lvl;
      case (click_st)
        ST_INIT: begin
          tick_cnt = '0;
          click_st = ST_WAIT;
        end
        ST_WAIT: begin
          if (push) begin
            click_st = ST_PUSH1;
            ev       = bmc_pkg::EV_FIRST_PUSH;
          end
        end
        ST_PUSH1: begin
          // release keeps the press count, so the gap timer starts from it
          if (!push) begin
            click_st = ST_GAP1;
            ev       = bmc_pkg::EV_FIRST_RELEASE;
          end else if (count_up_reaches(det_cfg.long_press)) begin
            tick_cnt = '0;
            click_st = ST_LONG1;
            ev       = bmc_pkg::EV_FIRST_LONG;
          end
        end
        ST_LONG1: begin
          if (push) begin
            if (count_up_reaches(det_cfg.long_repeat)) begin
              tick_cnt = '0;
              ev       = bmc_pkg::EV_FIRST_REPEAT;
            end
          end else begin
            tick_cnt = '0;
            click_st = ST_WAIT;
            ev       = bmc_pkg::EV_RESET;
          end
        end
        ST_GAP1: begin
          if (push) begin
            tick_cnt = '0;
            click_st = ST_PUSH2;
            ev       = bmc_pkg::EV_SECOND_PUSH;
          end else if (count_up_reaches(det_cfg.gap)) begin
            tick_cnt = '0;
            click_st = ST_WAIT;
            ev       = bmc_pkg::EV_SINGLE_DONE;
          end
        end
        ST_PUSH2: begin
          if (!push) begin
            tick_cnt = '0;
            click_st = ST_GAP2;
            ev       = bmc_pkg::EV_SECOND_RELEASE;
          end else if (count_up_reaches(det_cfg.long_press)) begin
            tick_cnt = '0;
            click_st = ST_LONG2;
            ev       = bmc_pkg::EV_SECOND_LONG;
          end
        end
        ST_LONG2: begin
          // release here drops back to the initial state, not the waiting one
          if (push) begin
            if (count_up_reaches(det_cfg.long_repeat)) begin
              tick_cnt = '0;
              ev       = bmc_pkg::EV_SECOND_REPEAT;
            end
          end else begin
            tick_cnt = '0;
            click_st = ST_INIT;
            ev       = bmc_pkg::EV_RESET;
          end
        end
        ST_GAP2: begin
          if (push) begin
            tick_cnt = '0;
            click_st = ST_PUSH3;
            ev       = bmc_pkg::EV_THIRD_PUSH;
          end else if (count_up_reaches(det_cfg.gap)) begin
            tick_cnt = '0;
            click_st = ST_WAIT;
            ev       = bmc_pkg::EV_DOUBLE_DONE;
          end
        end
        ST_PUSH3: begin
          if (!push) begin
            tick_cnt = '0;
            click_st = ST_WAIT;
            ev       = bmc_pkg::EV_TRIPLE_DONE;
          end
        end
        default: ;
      endcase
    end
    res.ev      = ev;
    res.pressed = stable_lvl;
    return res;
  endfunction

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      bmc_pkg::CFG_ENABLE:       det_cfg.enable       = data[0];
      bmc_pkg::CFG_ACTIVE_LEVEL: det_cfg.active_level = data[0];
      bmc_pkg::CFG_LONG_PRESS:   det_cfg.long_press   = data;
      bmc_pkg::CFG_LONG_REPEAT:  det_cfg.long_repeat  = data;
      bmc_pkg::CFG_GAP:          det_cfg.gap          = data;
      default: ;
    endcase
  endtask

  // Write every register, at times after a stray index; the one-bit ones carry random upper bits.
  task automatic apply_setup(logic en, logic act, cfg_data_t lp, cfg_data_t lr,
                             cfg_data_t gp);
    cfg_data_t junk;
    cfg_idx_t  stray;
    if ($urandom_range(0, 2) == 0) begin
      stray = cfg_idx_t'($urandom_range(STRAY_IDX_LO, STRAY_IDX_HI));
      write_reg(stray, cfg_data_t'($urandom));
    end
    junk = cfg_data_t'($urandom);
    write_reg(bmc_pkg::CFG_ENABLE, {junk[bmc_pkg::CFG_DATA_W-1:1], en});
    junk = cfg_data_t'($urandom);
    write_reg(bmc_pkg::CFG_ACTIVE_LEVEL, {junk[bmc_pkg::CFG_DATA_W-1:1], act});
    write_reg(bmc_pkg::CFG_LONG_PRESS, lp);
    write_reg(bmc_pkg::CFG_LONG_REPEAT, lr);
    write_reg(bmc_pkg::CFG_GAP, gp);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pin_backlog.size() != 0 || in_valid_i || pending_events.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_hold(logic lvl, int ticks, int bounce_pct);
    for (int k = 0; k < ticks; k++) begin
      pin_backlog.push_back(($urandom_range(0, 99) < bounce_pct) ? ~lvl : lvl);
      items_queued++;
    end
  endtask

  // One to three clicks, some held long enough for long press and repeats.
  task automatic queue_click_sequence(int bounce_pct);
    logic down;
    int   clicks;
    int   hold;
    int   release_ticks;
    int   gap_span;
    down     = det_cfg.active_level;
    clicks   = $urandom_range(1, 3);
    gap_span = clamp_ticks(int'(det_cfg.gap), 40);
    for (int c = 0; c < clicks; c++) begin
      if ($urandom_range(0, 3) == 0)
        hold = clamp_ticks(int'(det_cfg.long_press) + DEBOUNCE +
                           $urandom_range(0, 2 * int'(det_cfg.long_repeat) + 2), 48);
      else
        hold = $urandom_range(DEBOUNCE, DEBOUNCE + 5);
      queue_hold(down, hold, bounce_pct);
      if (c == clicks - 1)
        release_ticks = gap_span + DEBOUNCE + 4;
      else
        release_ticks = $urandom_range(DEBOUNCE, gap_span + DEBOUNCE + 2);
      queue_hold(~down, release_ticks, bounce_pct);
    end
  endtask

  function automatic cfg_data_t pick_threshold(int phase);
    int r;
    if (phase == 0) return cfg_data_t'(1);
    if (phase == 1) return '0;
    if (phase == 2) return '1;
    r = $urandom_range(0, 11);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return cfg_data_t'(1);
      3:       return cfg_data_t'($urandom_range(20, 40));
      default: return cfg_data_t'($urandom_range(2, 10));
    endcase
  endfunction

  // Pin driver: present the next sample after its drawn pause, hold while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pending_events.push_back(predict_tick(pin_level_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pin_gap > 0) begin
          in_valid_i <= 1'b0;
          pin_gap--;
        end else if (pin_backlog.size() != 0) begin
          in_valid_i  <= 1'b1;
          pin_level_i <= pin_backlog.pop_front();
          pin_gap = draw_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Event monitor: compare each beat with the oldest prediction, then stall at random.
  always @(posedge clk_i) begin
    click_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          $display("%0t: event beat with nothing predicted: event_res %0d pressed %0b",
                   $time, event_res_o, pressed_o);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (event_res_o !== want.ev) begin
            $display("%0t: event_res expected %0d, actual %0d", $time, want.ev, event_res_o);
            mismatches++;
          end
          if (pressed_o !== want.pressed) begin
            $display("%0t: pressed expected %0b, actual %0b", $time, want.pressed, pressed_o);
            mismatches++;
          end
        end
        res_wait = draw_pause();
      end
      if (res_wait > 0) begin
        out_stall_i <= 1'b1;
        res_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("button_multi_click_detector_test: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int   phase;
    int   phase_start;
    logic en;
    logic act;
    det_cfg.enable       = 1'b1;
    det_cfg.active_level = 1'b0;
    det_cfg.long_press   = bmc_pkg::LONG_PRESS_RST;
    det_cfg.long_repeat  = bmc_pkg::LONG_REPEAT_RST;
    det_cfg.gap          = bmc_pkg::GAP_RST;
    click_st   = ST_INIT;
    tick_cnt   = '0;
    smp_now    = 1'b0;
    smp_prev   = 1'b0;
    stable_lvl = 1'b0;
    stable_cnt = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Power-on setup: first tick only leaves the initial state.
    queue_hold(1'b1, 4, 0);
    wait_drained();

    // Short thresholds: long press with repeats, reset on release, then a press whose brief release is filtered out.
    apply_setup(1'b1, 1'b1, 16'd2, 16'd2, 16'd3);
    @(negedge clk_i);
    queue_hold(1'b1, 9, 0);
    queue_hold(1'b0, 4, 0);
    queue_hold(1'b1, 4, 0);
    queue_hold(1'b0, 3, 0);
    queue_hold(1'b1, 3, 0);
    wait_drained();

    // Disabled: machine held in its initial state, debouncer frozen.
    apply_setup(1'b0, 1'b1, 16'd2, 16'd2, 16'd3);
    @(negedge clk_i);
    queue_hold(1'b0, 3, 50);
    wait_drained();

    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      en  = ($urandom_range(0, 7) != 0) || (phase < 3);
      act = 1'($urandom_range(0, 1));
      apply_setup(en, act, pick_threshold(phase), pick_threshold(phase), pick_threshold(phase));
      @(negedge clk_i);
      steady      = ($urandom_range(0, 3) == 0);
      phase_start = items_queued;
      if (!en) begin
        queue_hold(1'b0, 30, 50);
      end else begin
        while (items_queued - phase_start < PHASE_ITEMS) begin
          if ($urandom_range(0, 9) == 0) queue_hold(1'b0, $urandom_range(2, 8), 50);
          else queue_click_sequence(($urandom_range(0, 3) == 0) ? 15 : 0);
        end
      end
      wait_drained();
      phase++;
    end

    if (mismatches == 0) begin
      $display("button_multi_click_detector_test: done, clean");
    end else begin
      $display("button_multi_click_detector_test: done, errors");
    end
    $finish;
  end

endmodule
